FILE: rtl/rvu_pkg.sv
// Shared widths, constants and bundle types of the refraction vector unit.
package rvu_pkg;

	localparam int VEC_W    = 18;
	localparam int VEC_FRAC = 16;
	localparam int IOR_W    = 16;
	localparam int IOR_FRAC = 12;
	localparam int ETA_FRAC = 32;

	// Refraction ratio eta, unsigned with ETA_FRAC fraction bits; 1/ior peaks at 2^44.
	localparam int ETA_W    = 45;
	localparam int ETA_LO_W = 22;
	localparam int ETA_HI_W = ETA_W - ETA_LO_W;

	// Clamped cosine and 1 - cos^2, unsigned with 2*VEC_FRAC fraction bits.
	localparam int C_W = 2 * VEC_FRAC + 1;
	localparam logic [C_W-1:0] ONE2 = C_W'(1) << (2 * VEC_FRAC);

	// Reciprocal divider: one quotient bit per cell.
	localparam int DIV_STEPS = ETA_W;
	localparam int NUM_W     = ETA_W;
	localparam int REM_W     = IOR_W;

	// Square root: one result bit per cell.
	localparam int SQ_STEPS = 17;
	localparam int ROOT_W   = SQ_STEPS;
	localparam int SQ_X_W   = 2 * SQ_STEPS;
	localparam int SQ_REM_W = ROOT_W + 2;

	// Derived product widths.
	localparam int E2_W    = 57;
	localparam int E2_LO_W = 28;
	localparam int EC_W    = 29;
	localparam int M_W     = 30;
	localparam int T_W     = 30;

	typedef logic [2:0][VEC_W-1:0] vec3_t;

	typedef struct packed {
		vec3_t            inc;
		vec3_t            norm;
		logic [IOR_W-1:0] ior;
		logic [C_W-1:0]   c;
		logic [C_W-1:0]   s;
		logic             neg;
	} front_t;

	typedef struct packed {
		vec3_t            inc;
		vec3_t            norm;
		logic [ETA_W-1:0] eta;
		logic [EC_W-1:0]  ec;
		logic             neg;
		logic             tir;
	} back_t;

endpackage

FILE: rtl/rvu_delay.sv
// Fixed-depth shift register that carries a bundle alongside a cell chain.
module rvu_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		tap_q[0] <= d;
		for (int i = 1; i < DEPTH; i++) begin
			tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

FILE: rtl/rvu_div_cell.sv
// One restoring division cell: settles one quotient bit and passes the remainder on.
module rvu_div_cell import rvu_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic             clk,
	input  logic [REM_W-1:0] rem_in,
	input  logic [ETA_W-1:0] quo_in,
	input  logic [NUM_W-1:0] num_in,
	input  logic [IOR_W-1:0] den_in,
	output logic [REM_W-1:0] rem_out,
	output logic [ETA_W-1:0] quo_out,
	output logic [NUM_W-1:0] num_out,
	output logic [IOR_W-1:0] den_out
);

	logic [REM_W:0] trial;
	logic [REM_W:0] diff;
	logic           ge;

	always_comb begin
		trial = {rem_in, num_in[BIT]};
		diff  = trial - {1'b0, den_in};
		ge    = (trial >= {1'b0, den_in});
	end

	always_ff @(posedge clk) begin
		rem_out <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
		quo_out <= {quo_in[ETA_W-2:0], ge};
		num_out <= num_in;
		den_out <= den_in;
	end

endmodule

FILE: rtl/rvu_sqrt_cell.sv
// One digit-by-digit square root cell: takes two radicand bits, yields one root bit.
module rvu_sqrt_cell import rvu_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic                clk,
	input  logic [SQ_X_W-1:0]   x_in,
	input  logic [SQ_REM_W-1:0] rem_in,
	input  logic [ROOT_W-1:0]   root_in,
	output logic [SQ_X_W-1:0]   x_out,
	output logic [SQ_REM_W-1:0] rem_out,
	output logic [ROOT_W-1:0]   root_out
);

	localparam int PAIR = SQ_STEPS - 1 - STEP;

	logic [SQ_REM_W+1:0] t;
	logic [SQ_REM_W+1:0] trial;
	logic [SQ_REM_W+1:0] diff;
	logic                ge;

	always_comb begin
		t     = {rem_in, x_in[2*PAIR+1 -: 2]};
		trial = {2'b00, root_in, 2'b01};
		diff  = t - trial;
		ge    = (t >= trial);
	end

	always_ff @(posedge clk) begin
		x_out    <= x_in;
		rem_out  <= ge ? diff[SQ_REM_W-1:0] : t[SQ_REM_W-1:0];
		root_out <= {root_in[ROOT_W-2:0], ge};
	end

endmodule

FILE: rtl/refraction_vector_unit_core.sv
// Refraction vector unit: Snell refraction of a direction about a surface normal.
// A new item is taken in every cycle, so throughput is one item per cycle and busy stays low.
// The depth is set by the 45-cell reciprocal divider chain and the 17-cell square root chain.
// Reset clears only the valid pipeline; results leave on done for one cycle each.
// The receiver cannot stall, so no result is ever held back.
module refraction_vector_unit_core import rvu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [VEC_W-1:0] inc_x,
	input  logic signed [VEC_W-1:0] inc_y,
	input  logic signed [VEC_W-1:0] inc_z,
	input  logic signed [VEC_W-1:0] norm_x,
	input  logic signed [VEC_W-1:0] norm_y,
	input  logic signed [VEC_W-1:0] norm_z,
	input  logic        [IOR_W-1:0] index_ratio,
	output logic                    done,
	output logic signed [VEC_W-1:0] out_x,
	output logic signed [VEC_W-1:0] out_y,
	output logic signed [VEC_W-1:0] out_z,
	output logic                    total_reflect
);

	localparam int LAT       = 70;
	localparam int FRONT_DLY = DIV_STEPS - 4;
	localparam int PROD_W    = 2 * VEC_W;
	localparam int DOT_W     = PROD_W + 1;
	localparam int E2SUM_W   = 2 * ETA_W - 1;
	localparam int ECSUM_W   = ETA_W + C_W - 1;
	localparam int E2SSUM_W  = E2_W + C_W - 1;
	localparam int T1SUM_W   = VEC_W + ETA_W - 1;
	localparam int T2P_W     = VEC_W + M_W - 1;

	// Every item moves one stage per cycle; only the valid chain needs reset.
	logic [LAT-1:0] vld_q;
	logic           accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	assign done = vld_q[LAT-1];

	// A zero index is treated as one LSB.
	logic [IOR_W-1:0] ior_in;
	assign ior_in = (index_ratio == '0) ? IOR_W'(1) : index_ratio;

	// ---------------------------------------------------------------------
	// Front end: dot product, clamp and sine squared.
	// ---------------------------------------------------------------------
	logic signed [PROD_W-1:0] prod_s1 [3];
	front_t                   fr_s1, fr_s2, fr_s3, fr_s4, fr_dly;
	logic [2*C_W-1:0]         cc_s3;
	logic signed [DOT_W-1:0]  dot_w;
	logic [DOT_W-1:0]         dmag_w;

	always_ff @(posedge clk) begin
		prod_s1[0]  <= PROD_W'(inc_x) * PROD_W'(norm_x);
		prod_s1[1]  <= PROD_W'(inc_y) * PROD_W'(norm_y);
		prod_s1[2]  <= PROD_W'(inc_z) * PROD_W'(norm_z);
		fr_s1.inc   <= {inc_z, inc_y, inc_x};
		fr_s1.norm  <= {norm_z, norm_y, norm_x};
		fr_s1.ior   <= ior_in;
		fr_s1.c     <= '0;
		fr_s1.s     <= '0;
		fr_s1.neg   <= 1'b0;
	end

	always_comb begin
		dot_w  = DOT_W'(prod_s1[0]) + DOT_W'(prod_s1[1]) + DOT_W'(prod_s1[2]);
		dmag_w = dot_w[DOT_W-1] ? DOT_W'(-dot_w) : DOT_W'(dot_w);
	end

	// A zero dot product counts as non-negative.
	always_ff @(posedge clk) begin
		fr_s2.inc  <= fr_s1.inc;
		fr_s2.norm <= fr_s1.norm;
		fr_s2.ior  <= fr_s1.ior;
		fr_s2.s    <= fr_s1.s;
		fr_s2.neg  <= dot_w[DOT_W-1];
		fr_s2.c    <= (dmag_w > DOT_W'(ONE2)) ? ONE2 : dmag_w[C_W-1:0];
	end

	always_ff @(posedge clk) begin
		fr_s3 <= fr_s2;
		cc_s3 <= (2*C_W)'(fr_s2.c) * (2*C_W)'(fr_s2.c);
	end

	always_ff @(posedge clk) begin
		fr_s4.inc  <= fr_s3.inc;
		fr_s4.norm <= fr_s3.norm;
		fr_s4.ior  <= fr_s3.ior;
		fr_s4.c    <= fr_s3.c;
		fr_s4.neg  <= fr_s3.neg;
		fr_s4.s    <= ONE2 - cc_s3[2*C_W-2:2*VEC_FRAC];
	end

	rvu_delay #(
		.WIDTH($bits(front_t)),
		.DEPTH(FRONT_DLY)
	) u_front_dly (
		.clk(clk),
		.d  (fr_s4),
		.q  (fr_dly)
	);

	// ---------------------------------------------------------------------
	// Reciprocal chain: round(2^44 / ior), one quotient bit per cell.
	// ---------------------------------------------------------------------
	logic [REM_W-1:0] drem [DIV_STEPS+1];
	logic [ETA_W-1:0] dquo [DIV_STEPS+1];
	logic [NUM_W-1:0] dnum [DIV_STEPS+1];
	logic [IOR_W-1:0] dden [DIV_STEPS+1];

	assign drem[0] = '0;
	assign dquo[0] = '0;
	assign dnum[0] = (NUM_W'(1) << (IOR_FRAC + ETA_FRAC)) | NUM_W'(ior_in >> 1);
	assign dden[0] = ior_in;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		rvu_div_cell #(
			.BIT(NUM_W - 1 - j)
		) u_cell (
			.clk    (clk),
			.rem_in (drem[j]),
			.quo_in (dquo[j]),
			.num_in (dnum[j]),
			.den_in (dden[j]),
			.rem_out(drem[j+1]),
			.quo_out(dquo[j+1]),
			.num_out(dnum[j+1]),
			.den_out(dden[j+1])
		);
	end

	// ---------------------------------------------------------------------
	// Middle: eta, eta^2, eta*cos, eta^2 * sine squared, k.
	// ---------------------------------------------------------------------
	front_t                        fr_s46, fr_s47, fr_s48, fr_s49;
	logic [ETA_W-1:0]              eta_s46, eta_s47, eta_s48, eta_s49, eta_s50;
	logic [2*ETA_HI_W-1:0]         hh_s47;
	logic [ETA_HI_W+ETA_LO_W-1:0]  hl_s47;
	logic [2*ETA_LO_W-1:0]         ll_s47;
	logic [ETA_HI_W+C_W-1:0]       hc_s47;
	logic [ETA_LO_W+C_W-1:0]       lc_s47;
	logic [E2_W-1:0]               e2_s48;
	logic [EC_W-1:0]               ec_s48, ec_s49, ec_s50;
	logic [E2_W-E2_LO_W+C_W-1:0]   pa_s49;
	logic [E2_LO_W+C_W-1:0]        pb_s49;
	logic [E2SUM_W-1:0]            e2sum_w;
	logic [ECSUM_W-1:0]            ecsum_w;
	logic [E2SSUM_W-1:0]           e2ssum_w;
	logic [E2_W-1:0]               e2s_w;
	logic                          tir_s50;
	logic [C_W-1:0]                k_s50;
	back_t                         bk_s50, bk_dly;

	// Entering light inverts the ratio; leaving light keeps ior and flips the normal.
	always_ff @(posedge clk) begin
		fr_s46  <= fr_dly;
		eta_s46 <= fr_dly.neg ? dquo[DIV_STEPS]
		                      : (ETA_W'(fr_dly.ior) << (ETA_FRAC - IOR_FRAC));
	end

	always_ff @(posedge clk) begin
		fr_s47  <= fr_s46;
		eta_s47 <= eta_s46;
		hh_s47  <= (2*ETA_HI_W)'(eta_s46[ETA_W-1:ETA_LO_W])
		         * (2*ETA_HI_W)'(eta_s46[ETA_W-1:ETA_LO_W]);
		hl_s47  <= (ETA_HI_W+ETA_LO_W)'(eta_s46[ETA_W-1:ETA_LO_W])
		         * (ETA_HI_W+ETA_LO_W)'(eta_s46[ETA_LO_W-1:0]);
		ll_s47  <= (2*ETA_LO_W)'(eta_s46[ETA_LO_W-1:0])
		         * (2*ETA_LO_W)'(eta_s46[ETA_LO_W-1:0]);
		hc_s47  <= (ETA_HI_W+C_W)'(eta_s46[ETA_W-1:ETA_LO_W]) * (ETA_HI_W+C_W)'(fr_s46.c);
		lc_s47  <= (ETA_LO_W+C_W)'(eta_s46[ETA_LO_W-1:0]) * (ETA_LO_W+C_W)'(fr_s46.c);
	end

	always_comb begin
		e2sum_w = (E2SUM_W'(hh_s47) << (2*ETA_LO_W)) + (E2SUM_W'(hl_s47) << (ETA_LO_W + 1))
		        + E2SUM_W'(ll_s47);
		ecsum_w = (ECSUM_W'(hc_s47) << ETA_LO_W) + ECSUM_W'(lc_s47);
	end

	always_ff @(posedge clk) begin
		fr_s48  <= fr_s47;
		eta_s48 <= eta_s47;
		e2_s48  <= e2sum_w[E2SUM_W-1:ETA_FRAC];
		ec_s48  <= ecsum_w[ECSUM_W-1:ETA_FRAC+VEC_FRAC];
	end

	always_ff @(posedge clk) begin
		fr_s49  <= fr_s48;
		eta_s49 <= eta_s48;
		ec_s49  <= ec_s48;
		pa_s49  <= (E2_W-E2_LO_W+C_W)'(e2_s48[E2_W-1:E2_LO_W]) * (E2_W-E2_LO_W+C_W)'(fr_s48.s);
		pb_s49  <= (E2_LO_W+C_W)'(e2_s48[E2_LO_W-1:0]) * (E2_LO_W+C_W)'(fr_s48.s);
	end

	always_comb begin
		e2ssum_w = (E2SSUM_W'(pa_s49) << E2_LO_W) + E2SSUM_W'(pb_s49);
		e2s_w    = e2ssum_w[E2SSUM_W-1:ETA_FRAC];
	end

	// When eta^2 (1 - cos^2) exceeds one, k is negative: total internal reflection.
	always_ff @(posedge clk) begin
		eta_s50 <= eta_s49;
		ec_s50  <= ec_s49;
		tir_s50 <= (e2s_w > E2_W'(ONE2));
		k_s50   <= ONE2 - e2s_w[C_W-1:0];
	end

	logic [2:0] dir_s50_unused_guard;
	assign dir_s50_unused_guard = '0;

	front_t fr_s50;
	always_ff @(posedge clk) begin
		fr_s50 <= fr_s49;
	end

	always_comb begin
		bk_s50.inc  = fr_s50.inc;
		bk_s50.norm = fr_s50.norm;
		bk_s50.eta  = eta_s50;
		bk_s50.ec   = ec_s50;
		bk_s50.neg  = fr_s50.neg | (dir_s50_unused_guard != '0);
		bk_s50.tir  = tir_s50;
	end

	rvu_delay #(
		.WIDTH($bits(back_t)),
		.DEPTH(SQ_STEPS)
	) u_back_dly (
		.clk(clk),
		.d  (bk_s50),
		.q  (bk_dly)
	);

	// ---------------------------------------------------------------------
	// Square root chain: floor(sqrt(k)), one root bit per cell.
	// ---------------------------------------------------------------------
	logic [SQ_X_W-1:0]   sx    [SQ_STEPS+1];
	logic [SQ_REM_W-1:0] srem  [SQ_STEPS+1];
	logic [ROOT_W-1:0]   sroot [SQ_STEPS+1];

	assign sx[0]    = SQ_X_W'(k_s50);
	assign srem[0]  = '0;
	assign sroot[0] = '0;

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		rvu_sqrt_cell #(
			.STEP(j)
		) u_cell (
			.clk     (clk),
			.x_in    (sx[j]),
			.rem_in  (srem[j]),
			.root_in (sroot[j]),
			.x_out   (sx[j+1]),
			.rem_out (srem[j+1]),
			.root_out(sroot[j+1])
		);
	end

	// ---------------------------------------------------------------------
	// Back end: I*eta + n*(eta*cos - sqrt(k)), truncated toward zero, saturated.
	// ---------------------------------------------------------------------
	logic signed [M_W-1:0]               m_s68;
	logic [VEC_W+ETA_HI_W-1:0]           t1h_s68 [3];
	logic [VEC_W+ETA_LO_W-1:0]           t1l_s68 [3];
	logic [2:0]                          isgn_s68, nneg_s68;
	logic [VEC_W-1:0]                    nmag_s68 [3];
	logic                                tir_s68, tir_s69;
	logic signed [T_W:0]                 t1_s69 [3];
	logic [T2P_W-1:0]                    t2p_s69 [3];
	logic [2:0]                          t2neg_s69;
	logic [VEC_W-1:0]                    imag_w [3];
	logic [VEC_W-1:0]                    nmag_w [3];
	logic [2:0]                          nneg_w;
	logic [M_W-2:0]                      mmag_w;
	logic [T1SUM_W-1:0]                  t1sum_w [3];
	logic signed [VEC_W-1:0]             res_w [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			imag_w[i] = bk_dly.inc[i][VEC_W-1] ? (~bk_dly.inc[i] + 1'b1) : bk_dly.inc[i];
			nmag_w[i] = bk_dly.norm[i][VEC_W-1] ? (~bk_dly.norm[i] + 1'b1) : bk_dly.norm[i];
			// Sign of the oriented normal component n = +N or -N.
			nneg_w[i] = bk_dly.neg ? bk_dly.norm[i][VEC_W-1]
			                       : ($signed(bk_dly.norm[i]) > $signed(VEC_W'(0)));
		end
	end

	always_ff @(posedge clk) begin
		m_s68   <= $signed(M_W'(bk_dly.ec)) - $signed(M_W'(sroot[SQ_STEPS]));
		tir_s68 <= bk_dly.tir;
		for (int i = 0; i < 3; i++) begin
			t1h_s68[i]  <= (VEC_W+ETA_HI_W)'(imag_w[i])
			             * (VEC_W+ETA_HI_W)'(bk_dly.eta[ETA_W-1:ETA_LO_W]);
			t1l_s68[i]  <= (VEC_W+ETA_LO_W)'(imag_w[i])
			             * (VEC_W+ETA_LO_W)'(bk_dly.eta[ETA_LO_W-1:0]);
			isgn_s68[i] <= bk_dly.inc[i][VEC_W-1];
			nneg_s68[i] <= nneg_w[i];
			nmag_s68[i] <= nmag_w[i];
		end
	end

	always_comb begin
		mmag_w = m_s68[M_W-1] ? (M_W-1)'(-m_s68) : m_s68[M_W-2:0];
		for (int i = 0; i < 3; i++) begin
			t1sum_w[i] = (T1SUM_W'(t1h_s68[i]) << ETA_LO_W) + T1SUM_W'(t1l_s68[i]);
		end
	end

	always_ff @(posedge clk) begin
		tir_s69 <= tir_s68;
		for (int i = 0; i < 3; i++) begin
			t1_s69[i]    <= isgn_s68[i] ? -$signed({1'b0, t1sum_w[i][T1SUM_W-1:ETA_FRAC]})
			                            :  $signed({1'b0, t1sum_w[i][T1SUM_W-1:ETA_FRAC]});
			t2p_s69[i]   <= T2P_W'(nmag_s68[i]) * T2P_W'(mmag_w);
			t2neg_s69[i] <= nneg_s68[i] ^ m_s68[M_W-1];
		end
	end

	always_comb begin
		logic signed [T_W+2:0] t2;
		logic signed [T_W+2:0] sum;
		for (int i = 0; i < 3; i++) begin
			t2  = t2neg_s69[i] ? -$signed((T_W+3)'(t2p_s69[i][T2P_W-1:VEC_FRAC]))
			                   :  $signed((T_W+3)'(t2p_s69[i][T2P_W-1:VEC_FRAC]));
			sum = (T_W+3)'(t1_s69[i]) + t2;
			if (sum > $signed((T_W+3)'((1 << (VEC_W-1)) - 1))) begin
				res_w[i] = VEC_W'((1 << (VEC_W-1)) - 1);
			end else if (sum < -$signed((T_W+3)'(1 << (VEC_W-1)))) begin
				res_w[i] = VEC_W'(1 << (VEC_W-1));
			end else begin
				res_w[i] = sum[VEC_W-1:0];
			end
		end
	end

	logic signed [VEC_W-1:0] out_s70 [3];
	logic                    tir_s70;

	// On total reflection the vector is forced to zero.
	always_ff @(posedge clk) begin
		tir_s70 <= tir_s69;
		for (int i = 0; i < 3; i++) begin
			out_s70[i] <= tir_s69 ? '0 : res_w[i];
		end
	end

	assign out_x         = out_s70[0];
	assign out_y         = out_s70[1];
	assign out_z         = out_s70[2];
	assign total_reflect = tir_s70;

endmodule
